// ----- sv/dpm_pkg.sv -----
package dpm_pkg;

    localparam int ACT_W      = 3;
    localparam int IDX_W      = 10;
    localparam int COORD_W    = 32;
    localparam int EP_W       = 8;
    localparam int ACNT_W     = 9;
    localparam int BCNT_W     = 10;
    localparam int ECNT_W     = BCNT_W + 1;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACT_W-1:0] ACT_LOAD_ATOM = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_EP   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RUN       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_KEEP = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_EP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOND_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd2;

    // 0.001 in Q16.16, rounded
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    typedef struct packed {
        logic coord_wr;      // load coordinates at the request index
        logic coord_rd;      // read coordinates at the sequencer atom address
        logic ref_load;      // latch coordinate read data as the reference atom
        logic keep_set;      // keep flag := 1 at the sequencer atom address
        logic keep_clr_dup;  // keep flag := 0 at the current duplicate
        logic keep_rd_item;  // read keep flag at the request index
        logic keep_rd_run;   // read keep flag at the sequencer atom address
        logic dup_wr;
        logic dup_rd;
        logic ep_load;       // load endpoint at the request index
        logic ep_rd_item;
        logic ep_rd_run;
        logic ep_fix;        // rewrite swept endpoint if it names the duplicate
        logic out_keep;
        logic out_ep;
        logic out_run;
    } t_cmd;

    typedef struct packed {
        logic              atom_ok;
        logic              ep_ok;
        logic              near;
        logic              keep_bit;
        logic              out_free;
        logic [ACNT_W-1:0] atom_cnt;
        logic [ECNT_W-1:0] ep_cnt;
    } t_status;

endpackage

// ----- sv/dpm_ctrl.sv -----
module dpm_ctrl #(
    parameter int MAX_ATOMS = 256,
    parameter int MAX_BONDS = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [dpm_pkg::ACT_W-1:0]     i_action,
    input  dpm_pkg::t_status              i_status,
    output logic                          o_in_stall,
    output dpm_pkg::t_cmd                 o_cmd,
    output logic [$clog2(MAX_ATOMS)-1:0]  o_atom_addr,
    output logic [$clog2(MAX_ATOMS)-1:0]  o_dup_waddr,
    output logic [$clog2(MAX_ATOMS)-1:0]  o_dup_wdata,
    output logic [$clog2(MAX_ATOMS)-1:0]  o_dup_raddr,
    output logic [$clog2(2*MAX_BONDS)-1:0] o_ep_addr,
    output logic [$clog2(2*MAX_BONDS)-1:0] o_ep_waddr,
    output logic [dpm_pkg::EP_W-1:0]      o_fix_atom
);
    import dpm_pkg::*;

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int EW = $clog2(2 * MAX_BONDS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_KEEP,
        S_RD_EP,
        S_MARK,
        S_A1_CHK,
        S_A1_WAIT,
        S_SCAN,
        S_DUP_RD,
        S_DUP_WAIT,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_a1;
    logic [AW:0]   r_a2;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_k;
    logic [EW:0]   r_e;
    logic          r_p1;
    logic [AW-1:0] r_p1_a2;
    logic          r_q1;
    logic [EW-1:0] r_q1_e;

    logic a2_in;
    logic a1_more;
    logic e_in;
    logic clr_last;
    logic dup_left;

    assign a2_in    = 32'(r_a2) < 32'(i_status.atom_cnt);
    assign a1_more  = (32'(r_a1) + 32'd1) < 32'(i_status.atom_cnt);
    assign e_in     = 32'(r_e) < 32'(i_status.ep_cnt);
    assign clr_last = 32'(r_a2) == 32'(MAX_ATOMS - 1);
    assign dup_left = r_k != r_cnt;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_atom_addr = (r_state == S_A1_CHK) ? r_a1 : r_a2[AW-1:0];
    assign o_dup_waddr = r_cnt;
    assign o_dup_wdata = r_p1_a2;
    assign o_dup_raddr = r_k;
    assign o_ep_addr   = r_e[EW-1:0];
    assign o_ep_waddr  = r_q1_e;
    assign o_fix_atom  = EP_W'(r_a1);

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: o_cmd.keep_set = 1'b1;
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        ACT_LOAD_ATOM: o_cmd.coord_wr     = i_status.atom_ok;
                        ACT_LOAD_EP:   o_cmd.ep_load      = i_status.ep_ok;
                        ACT_READ_KEEP: o_cmd.keep_rd_item = i_status.atom_ok;
                        ACT_READ_EP:   o_cmd.ep_rd_item   = i_status.ep_ok;
                        default: ;
                    endcase
                end
            end
            S_RD_KEEP: o_cmd.out_keep = i_status.out_free;
            S_RD_EP:   o_cmd.out_ep   = i_status.out_free;
            S_MARK:    o_cmd.keep_set = a2_in;
            S_A1_CHK: begin
                o_cmd.coord_rd    = a1_more;
                o_cmd.keep_rd_run = a1_more;
            end
            S_A1_WAIT: o_cmd.ref_load = i_status.keep_bit;
            S_SCAN: begin
                o_cmd.coord_rd = a2_in;
                o_cmd.dup_wr   = r_p1 && i_status.near;
            end
            S_DUP_RD:   o_cmd.dup_rd       = dup_left;
            S_DUP_WAIT: o_cmd.keep_clr_dup = 1'b1;
            S_SWEEP: begin
                o_cmd.ep_rd_run = e_in;
                o_cmd.ep_fix    = r_q1;
            end
            S_DONE: o_cmd.out_run = i_status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_a1    <= '0;
            r_a2    <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_e     <= '0;
            r_p1    <= 1'b0;
            r_p1_a2 <= '0;
            r_q1    <= 1'b0;
            r_q1_e  <= '0;
        end else begin
            unique case (r_state)
                // keep flags come out of reset as all ones
                S_CLEAR: begin
                    if (clr_last) begin
                        r_a2    <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_a2 <= r_a2 + (AW+1)'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_action)
                            ACT_RUN: begin
                                r_a2    <= '0;
                                r_state <= S_MARK;
                            end
                            ACT_READ_KEEP: begin
                                if (i_status.atom_ok) r_state <= S_RD_KEEP;
                            end
                            ACT_READ_EP: begin
                                if (i_status.ep_ok) r_state <= S_RD_EP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD_KEEP, S_RD_EP: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                S_MARK: begin
                    if (a2_in) begin
                        r_a2 <= r_a2 + (AW+1)'(1);
                    end else begin
                        r_a1    <= '0;
                        r_state <= S_A1_CHK;
                    end
                end
                S_A1_CHK: begin
                    r_state <= a1_more ? S_A1_WAIT : S_DONE;
                end
                S_A1_WAIT: begin
                    if (i_status.keep_bit) begin
                        r_a2    <= {1'b0, r_a1} + (AW+1)'(1);
                        r_cnt   <= '0;
                        r_p1    <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_a1    <= r_a1 + AW'(1);
                        r_state <= S_A1_CHK;
                    end
                end
                // one later atom per cycle, compared on the registered read data
                S_SCAN: begin
                    r_p1    <= a2_in;
                    r_p1_a2 <= r_a2[AW-1:0];
                    if (a2_in) r_a2 <= r_a2 + (AW+1)'(1);
                    if (r_p1 && i_status.near) r_cnt <= r_cnt + AW'(1);
                    if (!a2_in && !r_p1) begin
                        r_k     <= '0;
                        r_state <= S_DUP_RD;
                    end
                end
                S_DUP_RD: begin
                    if (dup_left) begin
                        r_state <= S_DUP_WAIT;
                    end else begin
                        r_a1    <= r_a1 + AW'(1);
                        r_state <= S_A1_CHK;
                    end
                end
                S_DUP_WAIT: begin
                    r_e     <= '0;
                    r_q1    <= 1'b0;
                    r_state <= S_SWEEP;
                end
                // read endpoint e, rewrite endpoint e-1
                S_SWEEP: begin
                    r_q1   <= e_in;
                    r_q1_e <= r_e[EW-1:0];
                    if (e_in) r_e <= r_e + (EW+1)'(1);
                    if (!e_in && !r_q1) begin
                        r_k     <= r_k + AW'(1);
                        r_state <= S_DUP_RD;
                    end
                end
                S_DONE: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/dpm_datapath.sv -----
module dpm_datapath #(
    parameter int MAX_ATOMS = 256,
    parameter int MAX_BONDS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [dpm_pkg::IDX_W-1:0]           i_item_index,
    input  logic signed [dpm_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [dpm_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [dpm_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [dpm_pkg::EP_W-1:0]            i_endpoint_atom_in,
    input  logic                                i_cfg_valid,
    input  logic [dpm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dpm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_out_stall,
    input  dpm_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(MAX_ATOMS)-1:0]        i_atom_addr,
    input  logic [$clog2(MAX_ATOMS)-1:0]        i_dup_waddr,
    input  logic [$clog2(MAX_ATOMS)-1:0]        i_dup_wdata,
    input  logic [$clog2(MAX_ATOMS)-1:0]        i_dup_raddr,
    input  logic [$clog2(2*MAX_BONDS)-1:0]      i_ep_addr,
    input  logic [$clog2(2*MAX_BONDS)-1:0]      i_ep_waddr,
    input  logic [dpm_pkg::EP_W-1:0]            i_fix_atom,
    output dpm_pkg::t_status                    o_status,
    output logic                                o_out_valid,
    output logic                                o_atom_kept,
    output logic [dpm_pkg::EP_W-1:0]            o_endpoint_atom_out,
    output logic                                o_run_done
);
    import dpm_pkg::*;

    localparam int AW     = $clog2(MAX_ATOMS);
    localparam int EW     = $clog2(2 * MAX_BONDS);
    localparam int EDEPTH = 2 * MAX_BONDS;

    logic [ACNT_W-1:0] r_atom_cnt;
    logic [BCNT_W-1:0] r_bond_cnt;
    logic [TOL_W-1:0]  r_tol;

    logic signed [COORD_W-1:0] r_x_mem [MAX_ATOMS];
    logic signed [COORD_W-1:0] r_y_mem [MAX_ATOMS];
    logic signed [COORD_W-1:0] r_z_mem [MAX_ATOMS];
    logic signed [COORD_W-1:0] r_x_q;
    logic signed [COORD_W-1:0] r_y_q;
    logic signed [COORD_W-1:0] r_z_q;
    logic signed [COORD_W-1:0] r_ref_x;
    logic signed [COORD_W-1:0] r_ref_y;
    logic signed [COORD_W-1:0] r_ref_z;

    logic          r_keep_mem [MAX_ATOMS];
    logic          r_keep_q;
    logic [AW-1:0] r_dup_mem [MAX_ATOMS];
    logic [AW-1:0] r_dup_q;
    logic [EP_W-1:0] r_ep_mem [EDEPTH];
    logic [EP_W-1:0] r_ep_q;

    logic r_out_valid;
    logic r_out_kept;
    logic [EP_W-1:0] r_out_ep;
    logic r_out_run;

    logic [AW-1:0]     item_atom;
    logic [EW-1:0]     item_ep;
    logic [ECNT_W-1:0] ep_cnt;
    logic [AW-1:0]     keep_raddr;
    logic [EW-1:0]     ep_raddr;
    logic [EW-1:0]     ep_waddr;
    logic [EP_W-1:0]   ep_wdata;
    logic              ep_we;
    logic              ep_match;
    logic              near;
    logic              out_free;

    function automatic logic axis_close(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic [TOL_W-1:0]          tol
    );
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] t;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        t = {{(COORD_W + 1 - TOL_W){1'b0}}, tol};
        return (d < t) && (d > -t);
    endfunction

    assign item_atom = AW'(i_item_index);
    assign item_ep   = EW'(i_item_index);
    assign ep_cnt    = {r_bond_cnt, 1'b0};

    // configuration registers, counts saturate at the storage depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom_cnt <= '0;
            r_bond_cnt <= '0;
            r_tol      <= TOL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATOM_COUNT: begin
                    if (32'(i_cfg_data[ACNT_W-1:0]) > 32'(MAX_ATOMS))
                        r_atom_cnt <= ACNT_W'(MAX_ATOMS);
                    else
                        r_atom_cnt <= i_cfg_data[ACNT_W-1:0];
                end
                CFG_BOND_COUNT: begin
                    if (32'(i_cfg_data[BCNT_W-1:0]) > 32'(MAX_BONDS))
                        r_bond_cnt <= BCNT_W'(MAX_BONDS);
                    else
                        r_bond_cnt <= i_cfg_data[BCNT_W-1:0];
                end
                CFG_TOLERANCE: r_tol <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coord_wr) r_x_mem[item_atom] <= i_coord_x;
        if (i_cmd.coord_rd) r_x_q <= r_x_mem[i_atom_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coord_wr) r_y_mem[item_atom] <= i_coord_y;
        if (i_cmd.coord_rd) r_y_q <= r_y_mem[i_atom_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coord_wr) r_z_mem[item_atom] <= i_coord_z;
        if (i_cmd.coord_rd) r_z_q <= r_z_mem[i_atom_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ref_load) begin
            r_ref_x <= r_x_q;
            r_ref_y <= r_y_q;
            r_ref_z <= r_z_q;
        end
    end

    assign near = axis_close(r_ref_x, r_x_q, r_tol) &&
                  axis_close(r_ref_y, r_y_q, r_tol) &&
                  axis_close(r_ref_z, r_z_q, r_tol);

    assign keep_raddr = i_cmd.keep_rd_item ? item_atom : i_atom_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.keep_set)
            r_keep_mem[i_atom_addr] <= 1'b1;
        else if (i_cmd.keep_clr_dup)
            r_keep_mem[r_dup_q] <= 1'b0;
        if (i_cmd.keep_rd_item || i_cmd.keep_rd_run)
            r_keep_q <= r_keep_mem[keep_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dup_wr) r_dup_mem[i_dup_waddr] <= i_dup_wdata;
        if (i_cmd.dup_rd) r_dup_q <= r_dup_mem[i_dup_raddr];
    end

    // an endpoint never matches an atom index beyond its own range
    assign ep_match = 32'(r_ep_q) == 32'(r_dup_q);
    assign ep_we    = i_cmd.ep_load || (i_cmd.ep_fix && ep_match);
    assign ep_waddr = i_cmd.ep_load ? item_ep : i_ep_waddr;
    assign ep_wdata = i_cmd.ep_load ? i_endpoint_atom_in : i_fix_atom;
    assign ep_raddr = i_cmd.ep_rd_item ? item_ep : i_ep_addr;

    always_ff @(posedge i_clk) begin
        if (ep_we) r_ep_mem[ep_waddr] <= ep_wdata;
        if (i_cmd.ep_rd_item || i_cmd.ep_rd_run) r_ep_q <= r_ep_mem[ep_raddr];
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_keep || i_cmd.out_ep || i_cmd.out_run) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.out_keep) begin
            r_out_kept <= r_keep_q;
            r_out_ep   <= '0;
            r_out_run  <= 1'b0;
        end else if (i_cmd.out_ep) begin
            r_out_kept <= 1'b0;
            r_out_ep   <= r_ep_q;
            r_out_run  <= 1'b0;
        end else if (i_cmd.out_run) begin
            r_out_kept <= 1'b0;
            r_out_ep   <= '0;
            r_out_run  <= 1'b1;
        end
    end

    assign o_status.atom_ok  = i_item_index < {1'b0, r_atom_cnt};
    assign o_status.ep_ok    = {1'b0, i_item_index} < ep_cnt;
    assign o_status.near     = near;
    assign o_status.keep_bit = r_keep_q;
    assign o_status.out_free = out_free;
    assign o_status.atom_cnt = r_atom_cnt;
    assign o_status.ep_cnt   = ep_cnt;

    assign o_out_valid         = r_out_valid;
    assign o_atom_kept         = r_out_kept;
    assign o_endpoint_atom_out = r_out_ep;
    assign o_run_done          = r_out_run;

endmodule

// ----- sv/duplicate_point_merger.sv -----
// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+-------------------------------------------
// request   | in  | i_in_valid / o_in_stall    | i_action i_item_index i_coord_x/y/z
//           |     |                            | i_endpoint_atom_in
// result    | out | o_out_valid / i_out_stall  | o_atom_kept o_endpoint_atom_out o_run_done
// config    | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// loads do not stall the request side; a read stalls it until its result enters the output register
// a run stalls it while it sets the keep flags below n, then for each a1 below n - 1 reads
// its flag; if kept, scans later atoms and sweeps endpoints per duplicate; n = atom_count
// results wait in one output register, a stalled result holds a pending read or run stalled
// after reset the keep flags of all MAX_ATOMS atoms are set with o_in_stall high;
// config writes are taken at any time
module duplicate_point_merger #(
    parameter int MAX_ATOMS = 256,
    parameter int MAX_BONDS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dpm_pkg::ACT_W-1:0]           i_action,
    input  logic [dpm_pkg::IDX_W-1:0]           i_item_index,
    input  logic signed [dpm_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [dpm_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [dpm_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [dpm_pkg::EP_W-1:0]            i_endpoint_atom_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_atom_kept,
    output logic [dpm_pkg::EP_W-1:0]            o_endpoint_atom_out,
    output logic                                o_run_done,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dpm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dpm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dpm_pkg::*;

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int EW = $clog2(2 * MAX_BONDS);

    t_cmd            cmd;
    t_status         status;
    logic [AW-1:0]   atom_addr;
    logic [AW-1:0]   dup_waddr;
    logic [AW-1:0]   dup_wdata;
    logic [AW-1:0]   dup_raddr;
    logic [EW-1:0]   ep_addr;
    logic [EW-1:0]   ep_waddr;
    logic [EP_W-1:0] fix_atom;

    assign o_cfg_ready = 1'b1;

    dpm_ctrl #(
        .MAX_ATOMS (MAX_ATOMS),
        .MAX_BONDS (MAX_BONDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd),
        .o_atom_addr (atom_addr),
        .o_dup_waddr (dup_waddr),
        .o_dup_wdata (dup_wdata),
        .o_dup_raddr (dup_raddr),
        .o_ep_addr   (ep_addr),
        .o_ep_waddr  (ep_waddr),
        .o_fix_atom  (fix_atom)
    );

    dpm_datapath #(
        .MAX_ATOMS (MAX_ATOMS),
        .MAX_BONDS (MAX_BONDS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_item_index        (i_item_index),
        .i_coord_x           (i_coord_x),
        .i_coord_y           (i_coord_y),
        .i_coord_z           (i_coord_z),
        .i_endpoint_atom_in  (i_endpoint_atom_in),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_out_stall         (i_out_stall),
        .i_cmd               (cmd),
        .i_atom_addr         (atom_addr),
        .i_dup_waddr         (dup_waddr),
        .i_dup_wdata         (dup_wdata),
        .i_dup_raddr         (dup_raddr),
        .i_ep_addr           (ep_addr),
        .i_ep_waddr          (ep_waddr),
        .i_fix_atom          (fix_atom),
        .o_status            (status),
        .o_out_valid         (o_out_valid),
        .o_atom_kept         (o_atom_kept),
        .o_endpoint_atom_out (o_endpoint_atom_out),
        .o_run_done          (o_run_done)
    );

endmodule

// ----- sv/dpm_checker.sv -----
module dpm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [dpm_pkg::ACT_W-1:0]           i_action,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_atom_kept,
    input logic [dpm_pkg::EP_W-1:0]            o_endpoint_atom_out,
    input logic                                o_run_done
);
    import dpm_pkg::*;

    logic accept;

    assign accept = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_atom_kept) &&
            $stable(o_endpoint_atom_out) && $stable(o_run_done))
        else $error("stalled result changed");

    // results only come out of a busy phase
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a busy phase");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_action == ACT_LOAD_ATOM || i_action == ACT_LOAD_EP) |=> !o_in_stall)
        else $error("load held the request side");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_action == ACT_RUN |=> o_in_stall)
        else $error("run did not start");

    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_atom_kept && (o_run_done || o_endpoint_atom_out != '0)) &&
            !(o_run_done && o_endpoint_atom_out != '0))
        else $error("result mixes fields of different requests");

endmodule

bind duplicate_point_merger dpm_checker u_dpm_checker (.*);
